FILE: src/hbpc_pkg.sv
// Shared constants, control types and the bigram hash for the hashed bigram pattern counter.
package hbpc_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int COUNT_WIDTH = 32;
    localparam int NUM_CELLS   = MAX_PATTERN - 1;
    localparam int HASH_W      = 9;
    localparam int LEN_W       = 7;
    localparam int BYTE_W      = 8;
    localparam int OUT_W       = 32;
    localparam int MIN_LEN     = 3;

    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef struct packed {
        logic              text_step;
        logic              clear;
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] wr_hash;
    } t_cell_ctl;

    function automatic logic [HASH_W-1:0] bigram_hash(input logic [BYTE_W-1:0] a,
                                                      input logic [BYTE_W-1:0] b);
        logic [BYTE_W+1:0] sum;
        sum = {1'b0, a, 1'b0} + {2'b00, b};
        return sum[HASH_W-1:0];
    endfunction

endpackage

FILE: src/hbpc_cell.sv
// One chain cell: a stored pattern bigram hash and its running match bit.
module hbpc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbpc_pkg::t_cell_ctl i_ctl,
    input  logic               i_wr_sel,
    input  logic               i_active,
    input  logic               i_top,
    input  logic               i_prev_bit,
    output logic               o_bit,
    output logic               o_tap
);
    import hbpc_pkg::*;

    logic [HASH_W-1:0] r_hash;
    logic              r_bit;
    logic              n_bit;

    assign n_bit = i_prev_bit && (r_hash == i_ctl.hash) && i_active;
    assign o_tap = i_ctl.text_step && n_bit && i_top;
    assign o_bit = r_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr_sel) begin
            r_hash <= i_ctl.wr_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.clear) begin
            r_bit <= 1'b0;
        end else if (i_ctl.text_step) begin
            r_bit <= n_bit;
        end
    end

endmodule

FILE: src/hashed_bigram_pattern_counter.sv
// Top level: hashed bigram pattern counter built as a chain of match cells.
//
// Input channel (i_valid/o_ready): each request carries i_func, i_data_byte, i_last.
//   i_func = 0 loads the next pattern byte, i_last closes the pattern.
//   i_func = 1 feeds the next text byte, i_last closes the text.
// Output channel (o_valid/i_ready): one request with o_match_count per text,
//   produced on the text byte that has i_last set.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data as the pattern length (used clamped to 3..64).
// Throughput: one request per cycle while o_ready is high; every cell compares the broadcast text
//   bigram hash in parallel and passes its match bit to the next cell.
// The count appears on o_valid the cycle after the last text byte.
// The output register decouples the sides; a new request is taken while the
//   result is pending only if i_ready takes that result in the same cycle.
// Reset (synchronous, i_rst_n low): length 3, counters, load position and
//   match bits cleared; stored pattern hashes are undefined until loaded.
module hashed_bigram_pattern_counter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [hbpc_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_func,
    input  logic [hbpc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hbpc_pkg::OUT_W-1:0] o_match_count
);
    import hbpc_pkg::*;

    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_load_pos;
    logic [BYTE_W-1:0]      r_prev_pat;
    logic [BYTE_W-1:0]      r_prev_text;
    logic                   r_text_started;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_count;

    logic [LEN_W-1:0]       eff_len;
    logic [LEN_W-1:0]       nbits;
    logic                   accept;
    logic                   pat_acc;
    logic                   txt_acc;
    logic                   wr_go;
    logic [LEN_W-1:0]       wr_idx;
    t_cell_ctl              ctl;
    logic [NUM_CELLS-1:0]   vec;
    logic [NUM_CELLS-1:0]   taps;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [63:0]            count_ext;

    always_comb begin
        priority if (r_len < LEN_W'(MIN_LEN)) begin
            eff_len = LEN_W'(MIN_LEN);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end
    assign nbits = eff_len - LEN_W'(1);

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign pat_acc = accept && (i_func == FUNC_PATTERN);
    assign txt_acc = accept && (i_func == FUNC_TEXT);

    assign wr_go  = pat_acc && (r_load_pos != '0) && (r_load_pos < LEN_W'(MAX_PATTERN));
    assign wr_idx = r_load_pos - LEN_W'(1);

    assign ctl.text_step = txt_acc && r_text_started;
    assign ctl.clear     = txt_acc && (!r_text_started || i_last);
    assign ctl.hash      = bigram_hash(r_prev_text, i_data_byte);
    assign ctl.wr_hash   = bigram_hash(r_prev_pat, i_data_byte);

    for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
        logic prev_bit;
        if (j == 0) begin : g_head
            assign prev_bit = 1'b1;
        end else begin : g_link
            assign prev_bit = vec[j-1];
        end
        hbpc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_wr_sel   (wr_go && (wr_idx == LEN_W'(j))),
            .i_active   (LEN_W'(j) < nbits),
            .i_top      (LEN_W'(j) == (nbits - LEN_W'(1))),
            .i_prev_bit (prev_bit),
            .o_bit      (vec[j]),
            .o_tap      (taps[j])
        );
    end

    assign hit = |taps;

    always_comb begin
        if (hit && (r_count != '1)) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end else begin
            n_count = r_count;
        end
    end
    assign count_ext = 64'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len          <= LEN_W'(MIN_LEN);
            r_load_pos     <= '0;
            r_prev_pat     <= '0;
            r_prev_text    <= '0;
            r_text_started <= 1'b0;
            r_count        <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            if (pat_acc) begin
                r_prev_pat <= i_data_byte;
                if (i_last) begin
                    r_load_pos <= '0;
                end else if (r_load_pos < LEN_W'(MAX_PATTERN)) begin
                    r_load_pos <= r_load_pos + LEN_W'(1);
                end
            end
            if (txt_acc) begin
                r_prev_text <= i_data_byte;
                if (i_last) begin
                    r_text_started <= 1'b0;
                    r_count        <= '0;
                end else begin
                    r_text_started <= 1'b1;
                    r_count        <= n_count;
                end
            end
            if (txt_acc && i_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (txt_acc && i_last) begin
            r_out_count <= count_ext[OUT_W-1:0];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_match_count = r_out_count;

    a_end_clears_vec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        txt_acc && i_last |=> (vec == '0) && !r_text_started && (r_count == '0))
        else $error("match state not cleared after text end");

    a_out_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(txt_acc && i_last))
        else $error("result without a closing text request");

    a_load_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pat_acc |=> (r_load_pos <= LEN_W'(MAX_PATTERN)))
        else $error("load position out of range");

    a_pattern_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pat_acc |=> $stable(r_count) && $stable(r_text_started))
        else $error("pattern load disturbed text state");

endmodule

FILE: tb/tb.sv
// Testbench for the hashed bigram pattern counter: self-checking, random bursts and stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hbpc_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 750;
    localparam int TEXT_GOAL    = 48;

    typedef struct {
        logic              func_bit;
        logic [BYTE_W-1:0] data_byte;
        logic              last_bit;
    } t_req;

    typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} t_ready_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]  i_cfg_wr_data = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_func = FUNC_PATTERN;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [OUT_W-1:0]  o_match_count;

    hashed_bigram_pattern_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_match_count (o_match_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Counter state as the block should hold it
    logic [HASH_W-1:0]    pat_hash [0:NUM_CELLS-1];
    logic [LEN_W-1:0]     load_pos = '0;
    logic [BYTE_W-1:0]    prev_pat_byte = '0;
    logic [BYTE_W-1:0]    prev_txt_byte = '0;
    logic                 txt_open = 1'b0;
    logic [NUM_CELLS-1:0] hit_vec = '0;
    logic [OUT_W-1:0]     occ_total = '0;
    logic [LEN_W-1:0]     len_reg = LEN_W'(MIN_LEN);

    logic [OUT_W-1:0] counts_due [$];
    t_req             req_fifo [$];

    // Stimulus-side shadow of which hash entries hold a value
    int               written = 0;
    int               gen_pos = 0;
    int               pat_len = 0;
    logic [BYTE_W-1:0] pat_bytes [0:MAX_PATTERN-1];
    int               cur_m = MIN_LEN;
    int               n_items = 0;
    int               n_texts = 0;
    int               errors = 0;
    int               cycles = 0;

    function automatic int clamp_len(input logic [LEN_W-1:0] v);
        int m;
        m = int'(v);
        if (m < MIN_LEN) m = MIN_LEN;
        if (m > MAX_PATTERN) m = MAX_PATTERN;
        return m;
    endfunction

    function automatic logic [HASH_W-1:0] fold_pair(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b);
        int s;
        s = (int'(a) * 2 + int'(b)) % 512;
        return s[HASH_W-1:0];
    endfunction

    function automatic void advance_counter(input logic fn, input logic [BYTE_W-1:0] b,
                                            input logic lst);
        int m;
        int j;
        logic [HASH_W-1:0]    h;
        logic [NUM_CELLS-1:0] hits;
        logic [NUM_CELLS-1:0] mask;
        if (fn == FUNC_PATTERN) begin
            if (load_pos == '0) begin
                load_pos = LEN_W'(1);
            end else if (load_pos < LEN_W'(MAX_PATTERN)) begin
                pat_hash[load_pos - LEN_W'(1)] = fold_pair(prev_pat_byte, b);
                load_pos = load_pos + LEN_W'(1);
            end
            prev_pat_byte = b;
            if (lst) load_pos = '0;
        end else begin
            if (!txt_open) begin
                txt_open = 1'b1;
                hit_vec = '0;
            end else begin
                m = clamp_len(len_reg);
                h = fold_pair(prev_txt_byte, b);
                hits = '0;
                for (j = 0; j < m - 1; j++) begin
                    if (pat_hash[j] == h) hits[j] = 1'b1;
                end
                mask = {NUM_CELLS{1'b1}} >> (NUM_CELLS - (m - 1));
                hit_vec = ((hit_vec << 1) | NUM_CELLS'(1)) & hits & mask;
                if (hit_vec[m - 2] && occ_total != {OUT_W{1'b1}})
                    occ_total = occ_total + OUT_W'(1);
            end
            prev_txt_byte = b;
            if (lst) begin
                counts_due.push_back(occ_total);
                occ_total = '0;
                hit_vec = '0;
                txt_open = 1'b0;
            end
        end
    endfunction

    function automatic void push_req(input logic fn, input logic [BYTE_W-1:0] b,
                                     input logic lst);
        t_req r;
        r.func_bit = fn;
        r.data_byte = b;
        r.last_bit = lst;
        req_fifo.push_back(r);
        n_items++;
        if (fn == FUNC_PATTERN) begin
            if (gen_pos == 0) begin
                gen_pos = 1;
                pat_len = 0;
            end else if (gen_pos < MAX_PATTERN) begin
                if (gen_pos > written) written = gen_pos;
                gen_pos++;
            end
            if (pat_len < MAX_PATTERN) pat_bytes[pat_len] = b;
            pat_len++;
            if (lst) gen_pos = 0;
        end else if (lst) begin
            n_texts++;
        end
    endfunction

    task automatic send_pattern(input int n);
        int k;
        for (k = 0; k < n; k++) push_req(FUNC_PATTERN, BYTE_W'($urandom), k == n - 1);
    endtask

    // Text with copies of the current pattern mixed into noise, now and then loading a new pattern
    task automatic send_text(input int n, input bit close);
        int i;
        int k;
        int c;
        logic [BYTE_W-1:0] b;
        i = 0;
        while (i < n) begin
            if (pat_len >= 2 && $urandom_range(0, 2) == 0) begin
                c = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
                if (c > n - i) c = n - i;
                for (k = 0; k < c; k++) begin
                    b = pat_bytes[k];
                    if ($urandom_range(0, 15) == 0) b = BYTE_W'($urandom);
                    push_req(FUNC_TEXT, b, close && (i == n - 1));
                    i++;
                end
            end else begin
                if ($urandom_range(0, 39) == 0) send_pattern($urandom_range(1, cur_m + 2));
                c = (pat_len > MAX_PATTERN) ? MAX_PATTERN : pat_len;
                if (c > 0 && $urandom_range(0, 1) == 0) b = pat_bytes[$urandom_range(0, c - 1)];
                else b = BYTE_W'($urandom);
                push_req(FUNC_TEXT, b, close && (i == n - 1));
                i++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_fifo.size() != 0 || i_valid || counts_due.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] v);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        len_reg = v;
        cur_m = clamp_len(v);
    endtask

    // Sender: bursts of requests separated by random gaps
    int   burst_left = 8;
    int   gap_left = 0;
    t_req nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) advance_counter(i_func, i_data_byte, i_last);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (req_fifo.size() > 0) begin
                    nxt = req_fifo.pop_front();
                    i_valid <= 1'b1;
                    i_func <= nxt.func_bit;
                    i_data_byte <= nxt.data_byte;
                    i_last <= nxt.last_bit;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = $urandom_range(1, 8);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks counts, stalls in changing patterns
    t_ready_mode      rdy_mode = RDY_ALWAYS;
    int               mode_left = 0;
    int               tick = 0;
    logic [OUT_W-1:0] want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (counts_due.size() == 0) begin
                    $error("match_count expected none actual %0d", o_match_count);
                    errors++;
                end else begin
                    want = counts_due.pop_front();
                    if (o_match_count !== want) begin
                        $error("match_count expected %0d actual %0d", want, o_match_count);
                        errors++;
                    end
                end
            end
            if (mode_left == 0) begin
                rdy_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
                tick = 0;
            end
            mode_left--;
            tick++;
            case (rdy_mode)
                RDY_ALWAYS: i_ready <= 1'b1;
                RDY_COIN:   i_ready <= ($urandom_range(0, 1) == 1);
                RDY_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default:    i_ready <= (tick % 12 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int base;
        int ph;
        int c;
        int m;
        int p;
        logic [LEN_W-1:0] raw;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_length(LEN_W'(MIN_LEN));
        // Extreme bytes, repeated overlapping hits
        push_req(FUNC_PATTERN, 8'hFF, 1'b0);
        push_req(FUNC_PATTERN, 8'h00, 1'b0);
        push_req(FUNC_PATTERN, 8'hFF, 1'b1);
        push_req(FUNC_TEXT, 8'hFF, 1'b0);
        push_req(FUNC_TEXT, 8'h00, 1'b0);
        push_req(FUNC_TEXT, 8'hFF, 1'b0);
        push_req(FUNC_TEXT, 8'h00, 1'b0);
        push_req(FUNC_TEXT, 8'hFF, 1'b1);
        // One-byte text
        push_req(FUNC_TEXT, 8'h00, 1'b1);
        // Hash collision: text 01 00 04 folds like pattern 00 02 00
        push_req(FUNC_PATTERN, 8'h00, 1'b0);
        push_req(FUNC_PATTERN, 8'h02, 1'b0);
        push_req(FUNC_PATTERN, 8'h00, 1'b1);
        push_req(FUNC_TEXT, 8'h01, 1'b0);
        push_req(FUNC_TEXT, 8'h00, 1'b0);
        push_req(FUNC_TEXT, 8'h04, 1'b1);
        // Pattern swapped in the middle of a text
        push_req(FUNC_TEXT, 8'h00, 1'b0);
        push_req(FUNC_TEXT, 8'h02, 1'b0);
        push_req(FUNC_PATTERN, 8'hFF, 1'b0);
        push_req(FUNC_PATTERN, 8'h00, 1'b0);
        push_req(FUNC_PATTERN, 8'hFF, 1'b1);
        push_req(FUNC_TEXT, 8'hFF, 1'b0);
        push_req(FUNC_TEXT, 8'h00, 1'b1);

        base = n_items;
        ph = 0;
        while (n_items - base < RANDOM_ITEMS || n_texts < TEXT_GOAL) begin
            case (ph)
                0: raw = 7'd0;
                1: raw = 7'd127;
                2: raw = 7'd64;
                3: raw = 7'd2;
                4: raw = 7'd1;
                5: raw = 7'd65;
                default: begin
                    c = $urandom_range(0, 9);
                    if (c < 7) raw = LEN_W'($urandom_range(3, 10));
                    else if (c < 9) raw = LEN_W'($urandom_range(11, 64));
                    else raw = LEN_W'($urandom_range(0, 127));
                end
            endcase
            set_length(raw);
            m = cur_m;
            if (written < m - 1 || ph == 1 || $urandom_range(0, 3) != 0) begin
                if (ph == 1 || (m == MAX_PATTERN && $urandom_range(0, 1) == 1))
                    p = $urandom_range(MAX_PATTERN + 1, MAX_PATTERN + 8);
                else if (written < m - 1) p = m + $urandom_range(0, 2);
                else p = $urandom_range(m - 2, m + 2);
                send_pattern(p);
            end
            repeat ($urandom_range(1, 4))
                send_text($urandom_range(1, 2 * m + 6), $urandom_range(0, 7) != 0);
            ph++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
